/* rtl/perlin_fractal_noise_pixel_macros.svh */
// Assertion macros shared by the noise pixel RTL.
`ifndef PERLIN_FRACTAL_NOISE_PIXEL_MACROS_SVH
`define PERLIN_FRACTAL_NOISE_PIXEL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfn check failed");

// Next-cycle implication, disabled during reset.
`define PFN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfn check failed");

`endif

/* rtl/pfn_pkg.sv */
// Shared types, constants and functions of the noise pixel block.
`timescale 1ns / 1ps
package pfn_pkg;

   localparam int IMAGE_SIZE_DEF = 1024;
   localparam int OCTAVES_DEF    = 4;
   localparam int ACC_W          = 40;
   localparam int CSR_IDX_W      = 4;
   localparam int CSR_DATA_W     = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_AMPLITUDE = 4'd1;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   localparam logic [2:0] OCTAVE_COUNT_RESET = 3'd4;
   localparam logic [9:0] BASE_AMP_RESET     = 10'd400;

   typedef struct packed {
      logic                    valid;
      logic [9:0]              x;
      logic [9:0]              y;
      logic signed [ACC_W-1:0] acc;
   } pfn_link_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  octave;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [31:0] data;
   } pfn_load_type;

   // 3t^2 - 2t^3 in Q0.48 from t^2 and t^3, rounded to Q0.16
   function automatic logic [16:0] smooth_of(logic [31:0] t2, logic [47:0] t3);
      logic [50:0] a;
      logic [50:0] num;
      a   = 51'({t2, 16'b0});
      num = a + (a << 1) - 51'({t3, 1'b0}) + (51'(1) << 31);
      return num[48:32];
   endfunction

endpackage

/* rtl/perlin_fractal_noise_pixel.sv */
// Top level of the multi-octave gradient noise pixel generator.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | func, pixel, octave, lattice, gradient
//  rsp_    | out       | rsp_valid/rsp_stall | noise_value, out_x, out_y
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// A load request is registered and then written into its octave's bank; loads do not
// stall the request channel. A pixel request is launched into the chain, runs through
// every active octave cell (four serial bank reads feeding the dot, weight, blend and
// scale pipeline), passes each idle cell, and is then captured, rounded and saturated.
// A new request is taken once the result is in the output register. A stalled result
// holds the chain's last value until taken. Reset is synchronous; it clears control
// state and restores the registers.
`timescale 1ns / 1ps
`include "perlin_fractal_noise_pixel_macros.svh"
module perlin_fractal_noise_pixel #(
   parameter int IMAGE_SIZE = pfn_pkg::IMAGE_SIZE_DEF,
   parameter int OCTAVES    = pfn_pkg::OCTAVES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [9:0]                          req_pixel_x,
   input  logic [9:0]                          req_pixel_y,
   input  logic [1:0]                          req_octave,
   input  logic [3:0]                          req_lattice_row,
   input  logic [3:0]                          req_lattice_col,
   input  logic signed [15:0]                  req_grad_x,
   input  logic signed [15:0]                  req_grad_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [19:0]                  rsp_noise_value,
   output logic [9:0]                          rsp_out_x,
   output logic [9:0]                          rsp_out_y,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfn_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_type;

   state_type state_ff;
   logic      req_take;
   logic      pixel_take;
   logic      run_start;
   logic [2:0] octave_count_ff, count_c;
   logic [9:0] base_amp_ff;
   pfn_pkg::pfn_load_type load_ff;
   pfn_pkg::pfn_link_type chain [OCTAVES+1];
   pfn_pkg::pfn_link_type start_ff;
   logic signed [pfn_pkg::ACC_W-1:0] acc_ff, rnd, res;
   logic signed [19:0] sat_in;
   logic        rsp_valid_ff;
   logic signed [19:0] noise_ff;
   logic [9:0]  x_ff, y_ff;
   logic [9:0]  out_x_ff, out_y_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign pixel_take = req_take && (req_func == pfn_pkg::FUNC_PIXEL);
   assign run_start  = (state_ff == ST_RUN) && chain[0].valid;
   assign csr_ready  = 1'b1;

   // configuration registers; unknown indexes do nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= pfn_pkg::OCTAVE_COUNT_RESET;
         base_amp_ff     <= pfn_pkg::BASE_AMP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pfn_pkg::CSR_OCTAVE_COUNT:   octave_count_ff <= csr_wdata[2:0];
            pfn_pkg::CSR_BASE_AMPLITUDE: base_amp_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the octave count to the cells actually built
   assign count_c = (int'(octave_count_ff) > OCTAVES) ? 3'(OCTAVES) : octave_count_ff;

   assign chain[0] = start_ff;

   for (genvar f = 0; f < OCTAVES; f++) begin : g_cell
      pfn_cell #(.IMAGE_SIZE(IMAGE_SIZE), .F(f)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .count    (count_c),
         .base_amp (base_amp_ff),
         .load     (load_ff),
         .link_in  (chain[f]),
         .link_out (chain[f+1])
      );
   end

   // round the Q.16 sum to Q.8 and saturate to 20 bits
   assign rnd = acc_ff + 40'sd128;
   assign res = rnd >>> 8;
   always_comb begin
      if (res > 40'sd524287) begin
         sat_in = 20'sd524287;
      end else if (res < -40'sd524288) begin
         sat_in = -20'sd524288;
      end else begin
         sat_in = 20'(res);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff.valid <= 1'b0;
         load_ff.valid  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         start_ff.valid <= 1'b0;
         load_ff.valid  <= req_take && (req_func == pfn_pkg::FUNC_LOAD);
         load_ff.octave <= req_octave;
         load_ff.row    <= req_lattice_row;
         load_ff.col    <= req_lattice_col;
         load_ff.data   <= {req_grad_x, req_grad_y};
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pixel_take) begin
                  start_ff.valid <= 1'b1;
                  start_ff.x     <= req_pixel_x;
                  start_ff.y     <= req_pixel_y;
                  start_ff.acc   <= '0;
                  x_ff           <= req_pixel_x;
                  y_ff           <= req_pixel_y;
                  state_ff       <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (chain[OCTAVES].valid) begin
                  acc_ff   <= chain[OCTAVES].acc;
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               // hold until the output register is free or being drained
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  noise_ff     <= sat_in;
                  out_x_ff     <= x_ff;
                  out_y_ff     <= y_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = noise_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;

   `PFN_ASSERT_NEXT(a_pixel_starts_run, clock, reset, pixel_take, run_start)
   `PFN_ASSERT_IMPLY(a_chain_done_in_run, clock, reset, chain[OCTAVES].valid, state_ff == ST_RUN)
   `PFN_ASSERT_IMPLY(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FIN))

endmodule

/* rtl/pfn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pfn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pfn_cell.sv */
// One octave cell: gradient bank, corner dot products, blend and scale.
`timescale 1ns / 1ps
module pfn_cell #(
   parameter int IMAGE_SIZE = pfn_pkg::IMAGE_SIZE_DEF,
   parameter int F          = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            count,
   input  logic [9:0]            base_amp,
   input  pfn_pkg::pfn_load_type load,
   input  pfn_pkg::pfn_link_type link_in,
   output pfn_pkg::pfn_link_type link_out
);

   localparam int L     = $clog2(IMAGE_SIZE + 1) - 1;
   localparam int S     = (L > F) ? L - F : 0;
   localparam int N     = (1 << F) + 1;
   localparam int DEPTH = N * N;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = F + 1;
   localparam logic [31:0] FRAC_MASK = 32'((1 << S) - 1);
   localparam logic [31:0] IDX_MASK  = 32'(IMAGE_SIZE - 1);
   localparam logic [3:0]  LAST_STEP = 4'd11;
   localparam logic [1:0]  C00 = 2'd0, C10 = 2'd1, C11 = 2'd2, C01 = 2'd3;

   logic        enabled;
   logic [31:0] xm, ym;
   logic [RW-1:0] ix_in, iy_in;
   logic [16:0] u_in, v_in;

   logic          busy_ff;
   logic [3:0]    step_ff;
   logic [RW-1:0] ix_ff, iy_ff;
   logic [16:0]   u_ff, v_ff;
   logic [9:0]    x_ff, y_ff;
   logic signed [pfn_pkg::ACC_W-1:0] acc_ff;
   pfn_pkg::pfn_link_type link_out_ff;

   logic [31:0] t2u_ff, t2v_ff;
   logic [47:0] t3u_ff, t3v_ff;
   logic [16:0] s1_ff, s2_ff, n1, n2;

   logic [1:0]    ck0;
   logic          vk0;
   logic [1:0]    ck1_ff, ck2_ff, ck3_ff, ck4_ff;
   logic          vk1_ff, vk2_ff, vk3_ff, vk4_ff, vk5_ff;
   logic [RW-1:0] row_rd, col_rd;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   rd_data;
   logic          wr_en;

   logic signed [15:0] gx, gy;
   logic signed [17:0] ox, oy;
   logic signed [33:0] px_ff, py_ff;
   logic signed [34:0] dsum;
   logic signed [19:0] d_ff;
   logic signed [17:0] wa, wb;
   logic signed [37:0] w_ff;
   logic signed [55:0] b_ff;
   logic signed [57:0] blend_ff, rsum;
   logic signed [25:0] term_ff;
   logic signed [10:0] amp;
   logic signed [36:0] prod_ff;

   assign enabled = int'(count) > F;
   assign xm      = {22'b0, link_in.x} & IDX_MASK;
   assign ym      = {22'b0, link_in.y} & IDX_MASK;
   assign ix_in   = RW'(xm >> S);
   assign iy_in   = RW'(ym >> S);
   assign u_in    = 17'((xm & FRAC_MASK) << (16 - S));
   assign v_in    = 17'((ym & FRAC_MASK) << (16 - S));

   // gradient bank: ignore loads outside this octave's lattice
   assign wr_en   = load.valid && (int'(load.octave) == F) &&
                    (int'(load.row) <= (1 << F)) && (int'(load.col) <= (1 << F));
   assign wr_addr = AW'(int'(load.row) * N + int'(load.col));

   assign ck0     = step_ff[1:0];
   assign vk0     = busy_ff && (step_ff[3:2] == 2'b00);
   assign row_rd  = ix_ff + RW'((ck0 == C10) || (ck0 == C11));
   assign col_rd  = iy_ff + RW'((ck0 == C11) || (ck0 == C01));
   assign rd_addr = AW'(int'(row_rd) * N + int'(col_rd));

   pfn_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_bank (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (load.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff           <= 1'b0;
         step_ff           <= 4'd0;
         link_out_ff.valid <= 1'b0;
         vk1_ff            <= 1'b0;
         vk2_ff            <= 1'b0;
         vk3_ff            <= 1'b0;
         vk4_ff            <= 1'b0;
         vk5_ff            <= 1'b0;
      end else begin
         link_out_ff.valid <= 1'b0;
         vk1_ff <= vk0;
         vk2_ff <= vk1_ff;
         vk3_ff <= vk2_ff;
         vk4_ff <= vk3_ff;
         vk5_ff <= vk4_ff;
         if (link_in.valid) begin
            if (enabled) begin
               busy_ff <= 1'b1;
               step_ff <= 4'd0;
            end else begin
               link_out_ff <= link_in;
            end
         end else if (busy_ff) begin
            step_ff <= step_ff + 4'd1;
            if (step_ff == LAST_STEP) begin
               busy_ff           <= 1'b0;
               link_out_ff.valid <= 1'b1;
               link_out_ff.x     <= x_ff;
               link_out_ff.y     <= y_ff;
               link_out_ff.acc   <= acc_ff + pfn_pkg::ACC_W'(prod_ff);
            end
         end
      end
   end

   assign gx = $signed(rd_data[31:16]);
   assign gy = $signed(rd_data[15:0]);
   assign ox = $signed({1'b0, u_ff}) - (((ck1_ff == C10) || (ck1_ff == C11)) ?
                                        18'sd65536 : 18'sd0);
   assign oy = $signed({1'b0, v_ff}) - (((ck1_ff == C11) || (ck1_ff == C01)) ?
                                        18'sd65536 : 18'sd0);
   assign dsum = 35'(px_ff) + 35'(py_ff) + 35'sd8192;
   assign n1   = 17'd65536 - s1_ff;
   assign n2   = 17'd65536 - s2_ff;

   always_comb begin
      case (ck3_ff)
         C00:     wa = $signed({1'b0, n1});
         C10:     wa = $signed({1'b0, s1_ff});
         C11:     wa = $signed({1'b0, s1_ff});
         default: wa = $signed({1'b0, n1});
      endcase
      case (ck4_ff)
         C00:     wb = $signed({1'b0, n2});
         C10:     wb = $signed({1'b0, n2});
         C11:     wb = $signed({1'b0, s2_ff});
         default: wb = $signed({1'b0, s2_ff});
      endcase
   end

   assign rsum = blend_ff + 58'sh80000000;
   assign amp  = $signed({1'b0, 10'(base_amp >> F)});

   always_ff @(posedge clock) begin
      if (link_in.valid) begin
         x_ff   <= link_in.x;
         y_ff   <= link_in.y;
         acc_ff <= link_in.acc;
         ix_ff  <= ix_in;
         iy_ff  <= iy_in;
         u_ff   <= u_in;
         v_ff   <= v_in;
      end
      t2u_ff  <= 32'(u_ff * u_ff);
      t2v_ff  <= 32'(v_ff * v_ff);
      t3u_ff  <= 48'(t2u_ff * u_ff);
      t3v_ff  <= 48'(t2v_ff * v_ff);
      s1_ff   <= pfn_pkg::smooth_of(t2u_ff, t3u_ff);
      s2_ff   <= pfn_pkg::smooth_of(t2v_ff, t3v_ff);
      ck1_ff  <= ck0;
      ck2_ff  <= ck1_ff;
      ck3_ff  <= ck2_ff;
      ck4_ff  <= ck3_ff;
      px_ff   <= ox * gx;
      py_ff   <= oy * gy;
      d_ff    <= 20'(dsum >>> 14);
      w_ff    <= d_ff * wa;
      b_ff    <= w_ff * wb;
      if (link_in.valid) begin
         blend_ff <= '0;
      end else if (vk5_ff) begin
         blend_ff <= blend_ff + 58'(b_ff);
      end
      term_ff <= 26'(rsum >>> 32);
      prod_ff <= term_ff * amp;
   end

   assign link_out = link_out_ff;

endmodule
